/* rtl/icc_ptc_pkg.sv */
// ---------------------------------------------------------------------------
// icc_ptc_pkg: shared types and constants for the parametric tone curve
// Sample width, fixed-point formats, config map, queue entry and the
// per-stage control word of the power pipeline.
// ---------------------------------------------------------------------------
package icc_ptc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

  // x = round(s * 2^30 / SMAX): series terms and correction steps
  localparam int XW    = 31;
  localparam int XK    = (SAMPLE_BITS + 30 + SAMPLE_BITS - 1) / SAMPLE_BITS;
  localparam int XCORR = XK + 2;

  localparam int VW = 50;  // signed curve value, Q30
  localparam int PW = 48;  // power term, Q30, saturates at 2^47

  localparam logic [30:0]   ONE_Q30 = 31'd1 << 30;
  localparam logic [29:0]   LN2_Q30 = 30'd744261118;
  localparam logic [PW-1:0] YSAT    = PW'(1) << 47;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Divide by Taylor index i: q = (n * M) >> (30 + L), exact for n < 2^30
  localparam int RECIP_L [16] = '{0, 1, 2, 2, 3, 3, 3, 3, 4, 4, 4, 4, 4, 4, 4, 4};
  localparam logic [63:0] RECIP_M [16] = '{
    ((64'd1 << 30) + 64'd0)  / 64'd1,
    ((64'd1 << 31) + 64'd1)  / 64'd2,
    ((64'd1 << 32) + 64'd2)  / 64'd3,
    ((64'd1 << 32) + 64'd3)  / 64'd4,
    ((64'd1 << 33) + 64'd4)  / 64'd5,
    ((64'd1 << 33) + 64'd5)  / 64'd6,
    ((64'd1 << 33) + 64'd6)  / 64'd7,
    ((64'd1 << 33) + 64'd7)  / 64'd8,
    ((64'd1 << 34) + 64'd8)  / 64'd9,
    ((64'd1 << 34) + 64'd9)  / 64'd10,
    ((64'd1 << 34) + 64'd10) / 64'd11,
    ((64'd1 << 34) + 64'd11) / 64'd12,
    ((64'd1 << 34) + 64'd12) / 64'd13,
    ((64'd1 << 34) + 64'd13) / 64'd14,
    ((64'd1 << 34) + 64'd14) / 64'd15,
    ((64'd1 << 34) + 64'd15) / 64'd16
  };

  typedef enum logic [2:0] {
    CT_POWER      = 3'd0,
    CT_OFFSET_CUT = 3'd1,
    CT_OFFSET_ADD = 3'd2,
    CT_LINEAR_TOE = 3'd3,
    CT_FULL       = 3'd4
  } curve_t;

  typedef enum logic [2:0] {
    REG_TYPE  = 3'd0,
    REG_GAMMA = 3'd1,
    REG_A     = 3'd2,
    REG_B     = 3'd3,
    REG_C     = 3'd4,
    REG_D     = 3'd5,
    REG_E     = 3'd6,
    REG_F     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]         curve_type;
    logic signed [31:0] gamma_exponent;
    logic signed [31:0] slope_a;
    logic signed [31:0] offset_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] break_d;
    logic signed [31:0] power_offset_e;
    logic signed [31:0] linear_offset_f;
  } cfg_t;

  // Classified item: power base plus what to add, or the final value
  typedef struct packed {
    logic                 use_pow;
    logic signed [63:0]   base;
    logic signed [VW-1:0] add;
    logic signed [VW-1:0] alt;
  } job_t;

  typedef struct packed {
    logic                 valid;
    logic                 use_pow;
    logic signed [VW-1:0] add;
    logic signed [VW-1:0] alt;
    logic                 sp;   // power term forced
    logic [PW-1:0]        spv;
  } ctl_t;

endpackage

/* rtl/icc_ptc_front.sv */
// ---------------------------------------------------------------------------
// icc_ptc_front: input scaling and curve segment selection
// Converts the sample to Q30, forms a*x+b, c*x and the break test, and
// classifies the item into a queue entry.
// ---------------------------------------------------------------------------
module icc_ptc_front import icc_ptc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                   fifo_full,
  output logic                   job_valid,
  output job_t                   job
);

  localparam int NW = SAMPLE_BITS + 30;
  localparam int RW = SAMPLE_BITS + 4;

  logic en;

  logic                   f1_v_r, f2_v_r, f3_v_r, f4_v_r, f5_v_r;
  logic [SAMPLE_BITS-1:0] f1_s_r;
  logic [XW-1:0]          f2_q_r;
  logic [RW-1:0]          f2_r_r;
  logic [XW-1:0]          f3_x_r, f4_x_r;
  logic signed [63:0]     f4_t_r, f4_cx_r;
  logic                   f4_up_r;
  job_t                   f5_job_r;

  logic [NW-1:0]      n, q0s;
  logic [NW:0]        rfull;
  logic [XW-1:0]      q_c;
  logic [RW-1:0]      r_c;
  logic signed [31:0] xs;
  logic signed [63:0] ax, bext, cx, xl, dl;
  logic signed [VW-1:0] lin, c14, e14, f14, xq;
  logic signed [63:0] xbase;
  job_t               job_nxt;

  assign en       = !f5_v_r || !fifo_full;
  assign in_stall = !en;

  // n = s*2^30 + SMAX/2; quotient by 2^N-1 from the shifted series
  always_comb begin
    n   = {f1_s_r, 30'd0} + NW'(SMAX >> 1);
    q0s = '0;
    for (int k = 1; k <= XK; k++) begin
      q0s = q0s + (n >> (k * SAMPLE_BITS));
    end
    rfull = {1'b0, n} - (NW+1)'({q0s[XW-1:0], {SAMPLE_BITS{1'b0}}})
            + (NW+1)'(q0s[XW-1:0]);
  end

  // series underestimates by a few; fix up with compare/subtract
  always_comb begin
    q_c = f2_q_r;
    r_c = f2_r_r;
    for (int k = 0; k < XCORR; k++) begin
      if (r_c >= RW'(SMAX)) begin
        r_c = r_c - RW'(SMAX);
        q_c = q_c + XW'(1);
      end
    end
  end

  assign xs   = {1'b0, f3_x_r};
  assign ax   = cfg.slope_a * xs;
  assign cx   = cfg.coef_c * xs;
  assign bext = {{2{cfg.offset_b[31]}}, cfg.offset_b, 30'd0};
  assign xl   = {33'd0, f3_x_r};
  assign dl   = {{18{cfg.break_d[31]}}, cfg.break_d, 14'd0};

  always_comb begin
    lin   = {{2{f4_cx_r[63]}}, f4_cx_r[63:16]};
    c14   = {{4{cfg.coef_c[31]}}, cfg.coef_c, 14'd0};
    e14   = {{4{cfg.power_offset_e[31]}}, cfg.power_offset_e, 14'd0};
    f14   = {{4{cfg.linear_offset_f[31]}}, cfg.linear_offset_f, 14'd0};
    xq    = {19'd0, f4_x_r};
    xbase = {17'd0, f4_x_r, 16'd0};
    job_nxt.use_pow = 1'b0;
    job_nxt.base    = f4_t_r;
    job_nxt.add     = '0;
    job_nxt.alt     = '0;
    unique case (cfg.curve_type)
      CT_POWER: begin
        job_nxt.use_pow = 1'b1;
        job_nxt.base    = xbase;
      end
      CT_OFFSET_CUT: begin
        job_nxt.use_pow = !f4_t_r[63];
      end
      CT_OFFSET_ADD: begin
        job_nxt.use_pow = !f4_t_r[63];
        job_nxt.add     = c14;
        job_nxt.alt     = c14;
      end
      CT_LINEAR_TOE: begin
        job_nxt.use_pow = f4_up_r;
        job_nxt.alt     = lin;
      end
      CT_FULL: begin
        job_nxt.use_pow = f4_up_r;
        job_nxt.add     = e14;
        job_nxt.alt     = lin + f14;
      end
      default: begin
        // unused type codes pass the clamped input through
        job_nxt.alt = xq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
      f4_v_r <= 1'b0;
      f5_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
      f4_v_r <= f3_v_r;
      f5_v_r <= f4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_s_r   <= in_sample_in;
      f2_q_r   <= q0s[XW-1:0];
      f2_r_r   <= rfull[RW-1:0];
      f3_x_r   <= q_c;
      f4_x_r   <= f3_x_r;
      f4_t_r   <= ax + bext;
      f4_cx_r  <= cx;
      f4_up_r  <= xl >= dl;
      f5_job_r <= job_nxt;
    end
  end

  assign job_valid = f5_v_r && !fifo_full;
  assign job       = f5_job_r;

endmodule

/* rtl/icc_ptc_fifo.sv */
// ---------------------------------------------------------------------------
// icc_ptc_fifo: short queue between classification and the power pipeline
// Register-based, one write and one read per cycle.
// ---------------------------------------------------------------------------
module icc_ptc_fifo import icc_ptc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_data,
  input  logic pop,
  output job_t rd_data,
  output logic full,
  output logic empty
);

  job_t                 mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     count_r;

  assign full    = count_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty   = count_r == '0;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a write");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count missed a read");

endmodule

/* rtl/icc_ptc_back.sv */
// ---------------------------------------------------------------------------
// icc_ptc_back: power pipeline, offset, clamp and output register
// log2 by 24 squaring stages, g*log2, 2^E by 16 Taylor terms, then
// segment combine and rescale to the sample range.
// ---------------------------------------------------------------------------
module icc_ptc_back import icc_ptc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic signed [31:0]     gamma,
  input  logic                   fifo_empty,
  input  job_t                   fifo_data,
  output logic                   fifo_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_sample_out
);

  localparam int NSQ   = 24;
  localparam int NTERM = 16;
  localparam int IS1   = 1;
  localparam int IS2   = 2;
  localparam int IE    = IS2 + NSQ + 1;
  localparam int IZ    = IE + 1;
  localparam int ISH   = IZ + 2 * NTERM + 1;
  localparam int IV    = ISH + 1;
  localparam int NST   = IV + 1;

  localparam longint E_HI = 64'sd17 <<< 30;
  localparam longint E_LO = -(64'sd40 <<< 30);

  logic en;
  ctl_t ctl_r [NST];
  ctl_t ctl_nxt [NST];

  logic signed [63:0] s0_base_r;
  logic [62:0]        s1_u_r;
  logic [5:0]         s1_p_r;
  logic [5:0]         p_c;
  logic [62:0]        m_c;

  logic [30:0]        sq_m_r [NSQ+1];
  logic [23:0]        sq_f_r [NSQ+1];
  logic signed [6:0]  lgi_r  [NSQ+1];

  logic signed [30:0] lg;
  logic signed [62:0] gl;
  logic signed [52:0] e_r;
  logic [59:0]        zp;

  logic [29:0]        tz_r [NTERM+1];
  logic signed [6:0]  tk_r [NTERM+1];
  logic [30:0]        tt_r [NTERM+1];
  logic [31:0]        ts_r [NTERM+1];
  logic [29:0]        tp_r [NTERM];
  logic [29:0]        za_r [NTERM];
  logic signed [6:0]  ka_r [NTERM];
  logic [31:0]        sa_r [NTERM];

  logic [PW-1:0]        pow_r, pow_c;
  logic [6:0]           negk;
  logic signed [VW-1:0] vs;
  logic [30:0]          v_r, v_c;
  logic [30+SAMPLE_BITS:0] scaled;
  logic                 out_valid_r;
  logic [SAMPLE_BITS-1:0] out_r;

  assign en       = !out_valid_r || !out_stall;
  assign fifo_pop = en && !fifo_empty;

  // control words ride along; special power values are set in two places
  always_comb begin
    ctl_nxt[0].valid   = fifo_pop;
    ctl_nxt[0].use_pow = fifo_data.use_pow;
    ctl_nxt[0].add     = fifo_data.add;
    ctl_nxt[0].alt     = fifo_data.alt;
    ctl_nxt[0].sp      = 1'b0;
    ctl_nxt[0].spv     = '0;
    for (int i = 1; i < NST; i++) begin
      ctl_nxt[i] = ctl_r[i-1];
    end
    // zero or negative base
    if (s0_base_r <= 64'sd0) begin
      ctl_nxt[IS1].sp = 1'b1;
      if (gamma > 32'sd0)       ctl_nxt[IS1].spv = '0;
      else if (gamma == 32'sd0) ctl_nxt[IS1].spv = PW'(ONE_Q30);
      else                      ctl_nxt[IS1].spv = YSAT;
    end
    // exponent out of range
    if (!ctl_r[IE].sp) begin
      if (64'(e_r) >= E_HI) begin
        ctl_nxt[IZ].sp  = 1'b1;
        ctl_nxt[IZ].spv = YSAT;
      end else if (64'(e_r) < E_LO) begin
        ctl_nxt[IZ].sp  = 1'b1;
        ctl_nxt[IZ].spv = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        ctl_r[i].valid <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctl_r       <= ctl_nxt;
      out_valid_r <= ctl_r[IV].valid;
    end
  end

  // leading one and normalization
  always_comb begin
    p_c = '0;
    for (int j = 0; j < 63; j++) begin
      if (s0_base_r[j]) p_c = 6'(j);
    end
    if (s1_p_r >= 6'd30) m_c = s1_u_r >> (s1_p_r - 6'd30);
    else                 m_c = s1_u_r << (6'd30 - s1_p_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_base_r <= fifo_data.base;
      s1_u_r    <= s0_base_r[62:0];
      s1_p_r    <= p_c;
      sq_m_r[0] <= m_c[30:0];
      sq_f_r[0] <= '0;
      lgi_r[0]  <= $signed({1'b0, s1_p_r}) - 7'sd46;
    end
  end

  // one fraction bit of log2 per squaring
  for (genvar j = 0; j < NSQ; j++) begin : g_sq
    logic [61:0] mm;
    logic [31:0] m2;
    assign mm = sq_m_r[j] * sq_m_r[j];
    assign m2 = mm[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        if (m2[31]) begin
          sq_m_r[j+1] <= m2[31:1];
          sq_f_r[j+1] <= sq_f_r[j] | (24'd1 << (23 - j));
        end else begin
          sq_m_r[j+1] <= m2[30:0];
          sq_f_r[j+1] <= sq_f_r[j];
        end
        lgi_r[j+1] <= lgi_r[j];
      end
    end
  end

  assign lg = {lgi_r[NSQ], sq_f_r[NSQ]};
  assign gl = gamma * lg;
  assign zp = e_r[29:0] * LN2_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      e_r     <= gl[62:10];
      tz_r[0] <= zp[59:30];
      tk_r[0] <= e_r[36:30];
      tt_r[0] <= ONE_Q30;
      ts_r[0] <= 32'(ONE_Q30);
    end
  end

  // Taylor series of 2^r: multiply by z, then divide by the term index
  for (genvar ti = 0; ti < NTERM; ti++) begin : g_term
    logic [60:0] pa, pb, pbs;
    logic [29:0] term;
    assign pa   = tt_r[ti] * tz_r[ti];
    assign pb   = tp_r[ti] * RECIP_M[ti][30:0];
    assign pbs  = pb >> (30 + RECIP_L[ti]);
    assign term = pbs[29:0];
    always_ff @(posedge clk) begin
      if (en) begin
        tp_r[ti]    <= pa[59:30];
        za_r[ti]    <= tz_r[ti];
        ka_r[ti]    <= tk_r[ti];
        sa_r[ti]    <= ts_r[ti];
        tt_r[ti+1]  <= {1'b0, term};
        ts_r[ti+1]  <= sa_r[ti] + 32'(term);
        tz_r[ti+1]  <= za_r[ti];
        tk_r[ti+1]  <= ka_r[ti];
      end
    end
  end

  // scale by 2^k, then combine and clamp
  always_comb begin
    negk = -tk_r[NTERM];
    if (ctl_r[ISH-1].sp)        pow_c = ctl_r[ISH-1].spv;
    else if (!tk_r[NTERM][6])   pow_c = PW'(ts_r[NTERM]) << tk_r[NTERM][4:0];
    else                        pow_c = PW'(ts_r[NTERM] >> negk[5:0]);

    if (ctl_r[ISH].use_pow) vs = $signed({{(VW-PW){1'b0}}, pow_r}) + ctl_r[ISH].add;
    else                    vs = ctl_r[ISH].alt;
    if (vs[VW-1])                          v_c = '0;
    else if (vs > $signed(VW'(ONE_Q30)))   v_c = ONE_Q30;
    else                                   v_c = vs[30:0];

    scaled = (31+SAMPLE_BITS)'(v_r) * (31+SAMPLE_BITS)'(SMAX)
             + (31+SAMPLE_BITS)'(ONE_Q30 >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pow_r <= pow_c;
      v_r   <= v_c;
      out_r <= scaled[30+SAMPLE_BITS-1:30];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

endmodule

/* rtl/icc_parametric_tone_curve.sv */
// ---------------------------------------------------------------------------
// icc_parametric_tone_curve: ICC parametric curve on one channel sample
// Config registers, front classification, queue and power pipeline.
// ---------------------------------------------------------------------------
//   channel   dir   handshake          payload
//   in        in    in_valid/in_stall   in_sample_in [SAMPLE_BITS]
//   out       out   out_valid/out_stall out_sample_out [SAMPLE_BITS]
//   cfg       in    cfg_we              cfg_index [3], cfg_wdata [32]
//
// One sample per clock sustained while out_stall is low; every stage is fully pipelined.
// The path runs through 5 front stages, the queue, 63 power stages
// (24 squaring steps for log2, 32 for the Taylor terms) and the output reg.
// rst_n is synchronous; it clears valids, queue and config registers to defaults.
// out_stall freezes the power pipeline; the 4-entry queue lets the front
// keep taking samples until it fills, then in_stall rises.
// ---------------------------------------------------------------------------
module icc_parametric_tone_curve import icc_ptc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_sample_out
);

  cfg_t cfg_r;
  job_t job, fifo_data;
  logic job_valid, fifo_full, fifo_empty, fifo_pop;

  // register file; the user must write only while no transfer is in flight; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curve_type      <= CT_POWER;
      cfg_r.gamma_exponent  <= 32'sd65536;
      cfg_r.slope_a         <= 32'sd65536;
      cfg_r.offset_b        <= '0;
      cfg_r.coef_c          <= '0;
      cfg_r.break_d         <= '0;
      cfg_r.power_offset_e  <= '0;
      cfg_r.linear_offset_f <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TYPE:  cfg_r.curve_type      <= cfg_wdata[2:0];
        REG_GAMMA: cfg_r.gamma_exponent  <= cfg_wdata;
        REG_A:     cfg_r.slope_a         <= cfg_wdata;
        REG_B:     cfg_r.offset_b        <= cfg_wdata;
        REG_C:     cfg_r.coef_c          <= cfg_wdata;
        REG_D:     cfg_r.break_d         <= cfg_wdata;
        REG_E:     cfg_r.power_offset_e  <= cfg_wdata;
        REG_F:     cfg_r.linear_offset_f <= cfg_wdata;
      endcase
    end
  end

  icc_ptc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_in (in_sample_in),
    .fifo_full    (fifo_full),
    .job_valid    (job_valid),
    .job          (job)
  );

  icc_ptc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_valid),
    .wr_data (job),
    .pop     (fifo_pop),
    .rd_data (fifo_data),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  // power pipeline; the output register is its last stage
  icc_ptc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .gamma          (cfg_r.gamma_exponent),
    .fifo_empty     (fifo_empty),
    .fifo_data      (fifo_data),
    .fifo_pop       (fifo_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

endmodule
